[src/sndp_pkg.sv]
// ----------------------------------------------------------------------------
// sndp_pkg
// shared types and constants of the softsign neuron dot product
// ----------------------------------------------------------------------------
package sndp_pkg;

    localparam int unsigned VAL_W      = 16;  // q8.8 inputs, q2.14 weights, q8.8 bias
    localparam int unsigned NUM_INPUTS = 8;   // input elements carried by one item
    localparam int unsigned CNT_W      = 4;   // present and active counts
    localparam int unsigned PROD_W     = 32;  // one lane product, q10.22
    localparam int unsigned SUM_W      = 36;  // full weighted sum plus bias, q14.22
    localparam int unsigned DIV_W      = 36;  // divider remainder and divisor
    localparam int unsigned QUO_W      = 15;  // softsign magnitude, q0.15
    localparam int unsigned BIAS_SH    = 14;  // q8.8 to q10.22 alignment
    localparam int unsigned FRAC_BITS  = 22;  // fraction bits of the sum
    localparam int unsigned CFG_IDX_W  = 8;
    localparam int unsigned CFG_DAT_W  = 64;
    localparam int unsigned GROUP_SIZE = 4;   // weights packed in one group register

    localparam logic [DIV_W-1:0] ONE_Q22      = DIV_W'(1) << FRAC_BITS;
    localparam logic [CNT_W-1:0] ACTIVE_RESET = CNT_W'(8);

    // configuration register map
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WEIGHTS_LOW  = 8'd0,
        REG_WEIGHTS_HIGH = 8'd1,
        REG_BIAS         = 8'd2,
        REG_ACTIVE_COUNT = 8'd3
    } t_reg_idx;

    // control carried alongside each transaction through the pipeline
    typedef struct packed {
        logic vld;
        logic neg;
        logic too_few;
    } t_tag;

    // one divider stage worth of state
    typedef struct packed {
        t_tag             tag;
        logic [DIV_W-1:0] rem;
        logic [DIV_W-1:0] dvs;
        logic [QUO_W-1:0] quo;
    } t_div_bus;

endpackage

[src/sndp_in_if.sv]
// ----------------------------------------------------------------------------
// sndp_in_if
// input vector channel: eight q8.8 elements and a present count
// ----------------------------------------------------------------------------
interface sndp_in_if;

    logic                                valid;
    logic                                ready;
    logic signed [sndp_pkg::VAL_W-1:0]   input_value_0;
    logic signed [sndp_pkg::VAL_W-1:0]   input_value_1;
    logic signed [sndp_pkg::VAL_W-1:0]   input_value_2;
    logic signed [sndp_pkg::VAL_W-1:0]   input_value_3;
    logic signed [sndp_pkg::VAL_W-1:0]   input_value_4;
    logic signed [sndp_pkg::VAL_W-1:0]   input_value_5;
    logic signed [sndp_pkg::VAL_W-1:0]   input_value_6;
    logic signed [sndp_pkg::VAL_W-1:0]   input_value_7;
    logic        [sndp_pkg::CNT_W-1:0]   present_count;

    modport source (
        output valid, input ready,
        output input_value_0, input_value_1, input_value_2, input_value_3,
        output input_value_4, input_value_5, input_value_6, input_value_7,
        output present_count
    );

    modport sink (
        input valid, output ready,
        input input_value_0, input_value_1, input_value_2, input_value_3,
        input input_value_4, input_value_5, input_value_6, input_value_7,
        input present_count
    );

endinterface

[src/sndp_out_if.sv]
// ----------------------------------------------------------------------------
// sndp_out_if
// result channel: q1.15 activation and the too-few-inputs flag
// ----------------------------------------------------------------------------
interface sndp_out_if;

    logic                               valid;
    logic                               ready;
    logic signed [sndp_pkg::VAL_W-1:0]  activation;
    logic                               too_few_inputs;

    modport source (output valid, input ready, output activation, output too_few_inputs);
    modport sink   (input valid, output ready, input activation, input too_few_inputs);

endinterface

[src/sndp_cfg_if.sv]
// ----------------------------------------------------------------------------
// sndp_cfg_if
// configuration write channel: register index and write data
// ----------------------------------------------------------------------------
interface sndp_cfg_if;

    logic                               valid;
    logic                               ready;
    logic [sndp_pkg::CFG_IDX_W-1:0]     index;
    logic [sndp_pkg::CFG_DAT_W-1:0]     data;

    modport source (output valid, input ready, output index, output data);
    modport sink   (input valid, output ready, input index, input data);

endinterface

[src/sndp_lane.sv]
// ----------------------------------------------------------------------------
// sndp_lane
// one multiply lane: input element times weight, zero when the lane is unused
// ----------------------------------------------------------------------------
module sndp_lane (
    input  logic                                  i_clk,
    input  logic                                  i_en,
    input  logic                                  i_use,
    input  logic signed [sndp_pkg::VAL_W-1:0]     i_x,
    input  logic signed [sndp_pkg::VAL_W-1:0]     i_w,
    output logic signed [sndp_pkg::PROD_W-1:0]    o_prod
);

    logic signed [sndp_pkg::PROD_W-1:0] r_prod;
    logic signed [sndp_pkg::PROD_W-1:0] n_prod;

    always_comb begin
        if (i_use) begin
            n_prod = sndp_pkg::PROD_W'(i_x) * sndp_pkg::PROD_W'(i_w);
        end else begin
            n_prod = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= n_prod;
        end
    end

    assign o_prod = r_prod;

endmodule

[src/sndp_merge.sv]
// ----------------------------------------------------------------------------
// sndp_merge
// merges lane products: pair sums, total plus bias, then magnitude and divisor
// ----------------------------------------------------------------------------
module sndp_merge #(
    parameter int unsigned NUM_WEIGHTS = 8
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_en,
    input  sndp_pkg::t_tag                        i_tag,
    input  logic signed [sndp_pkg::PROD_W-1:0]    i_prod [NUM_WEIGHTS],
    input  logic signed [sndp_pkg::VAL_W-1:0]     i_bias,
    output sndp_pkg::t_div_bus                    o_div
);

    localparam int unsigned NPAIR = (NUM_WEIGHTS + 1) / 2;

    logic signed [sndp_pkg::SUM_W-1:0] r_part [NPAIR];
    logic signed [sndp_pkg::SUM_W-1:0] n_part [NPAIR];
    sndp_pkg::t_tag                    r_tag_part;
    logic signed [sndp_pkg::SUM_W-1:0] r_sum;
    logic signed [sndp_pkg::SUM_W-1:0] n_sum;
    sndp_pkg::t_tag                    r_tag_sum;
    sndp_pkg::t_div_bus                r_div;
    sndp_pkg::t_div_bus                n_div;
    logic        [sndp_pkg::DIV_W-1:0] w_mag;

    // first level: neighbouring lanes added in pairs
    for (genvar j = 0; j < NPAIR; j++) begin : g_pair
        if (2 * j + 1 < NUM_WEIGHTS) begin : g_two
            assign n_part[j] = sndp_pkg::SUM_W'(i_prod[2*j])
                             + sndp_pkg::SUM_W'(i_prod[2*j+1]);
        end else begin : g_one
            assign n_part[j] = sndp_pkg::SUM_W'(i_prod[2*j]);
        end
    end

    // second level: pair sums plus the aligned bias
    always_comb begin
        n_sum = sndp_pkg::SUM_W'(i_bias) <<< sndp_pkg::BIAS_SH;
        for (int k = 0; k < NPAIR; k++) begin
            n_sum = n_sum + r_part[k];
        end
    end

    // third level: sign, magnitude and divisor one plus magnitude
    always_comb begin
        n_div         = '0;
        n_div.tag     = r_tag_sum;
        n_div.tag.neg = r_sum[sndp_pkg::SUM_W-1];
        w_mag         = n_div.tag.neg ? sndp_pkg::DIV_W'(-r_sum) : sndp_pkg::DIV_W'(r_sum);
        n_div.rem     = w_mag;
        n_div.dvs     = sndp_pkg::ONE_Q22 + w_mag;
        n_div.quo     = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag_part.vld <= 1'b0;
            r_tag_sum.vld  <= 1'b0;
            r_div.tag.vld  <= 1'b0;
        end else if (i_en) begin
            r_tag_part <= i_tag;
            r_part     <= n_part;
            r_tag_sum  <= r_tag_part;
            r_sum      <= n_sum;
            r_div      <= n_div;
        end
    end

    assign o_div = r_div;

endmodule

[src/sndp_div_stage.sv]
// ----------------------------------------------------------------------------
// sndp_div_stage
// one restoring division step: doubles the remainder, yields one quotient bit
// ----------------------------------------------------------------------------
module sndp_div_stage (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  sndp_pkg::t_div_bus     i_div,
    output sndp_pkg::t_div_bus     o_div
);

    sndp_pkg::t_div_bus              r_div;
    sndp_pkg::t_div_bus              n_div;
    logic [sndp_pkg::DIV_W:0]        w_dbl;
    logic [sndp_pkg::DIV_W:0]        w_diff;
    logic                            w_bit;

    // remainder stays below the divisor, so the doubled value fits one extra bit
    always_comb begin
        w_dbl  = {i_div.rem, 1'b0};
        w_diff = w_dbl - {1'b0, i_div.dvs};
        w_bit  = !w_diff[sndp_pkg::DIV_W];
        n_div      = i_div;
        n_div.rem  = w_bit ? w_diff[sndp_pkg::DIV_W-1:0] : w_dbl[sndp_pkg::DIV_W-1:0];
        n_div.quo  = {i_div.quo[sndp_pkg::QUO_W-2:0], w_bit};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div.tag.vld <= 1'b0;
        end else if (i_en) begin
            r_div <= n_div;
        end
    end

    assign o_div = r_div;

endmodule

[src/softsign_neuron_dot_product.sv]
// ----------------------------------------------------------------------------
// softsign_neuron_dot_product
// one neuron: weighted sum of up to eight q8.8 inputs plus bias, softsign out
// ----------------------------------------------------------------------------
// The block accepts one input vector every clock unless stalled and returns
// one q1.15 result per transaction, in order. Each transaction passes through
// the multiply lanes, the merging adder tree (pair sums, total with bias,
// magnitude and divisor), the pipelined restoring divider that forms
// |s| * 2^15 / (2^22 + |s|) one quotient bit per stage, and the output
// register that applies the sign. The whole pipeline moves as one; it holds
// only while the output register is full and not taken, so input ready is
// combinational from output ready. When the present count is below
// the active weight count the result is 0 with too_few_inputs set. The four
// configuration registers (weights 0..3, weights 4..7, bias, active weight
// count) are written through the configuration channel, which is always
// ready; writes to an unknown index are dropped. Active counts above the
// number of lanes are clamped to it.
// ----------------------------------------------------------------------------
module softsign_neuron_dot_product #(
    parameter int unsigned NUM_WEIGHTS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sndp_in_if.sink     i_data,
    sndp_cfg_if.sink    i_cfg,
    sndp_out_if.source  o_result
);

    localparam logic [sndp_pkg::CNT_W-1:0] LANES = sndp_pkg::CNT_W'(NUM_WEIGHTS);

    // configuration registers
    logic [sndp_pkg::CFG_DAT_W-1:0]      r_weights_low;
    logic [sndp_pkg::CFG_DAT_W-1:0]      r_weights_high;
    logic signed [sndp_pkg::VAL_W-1:0]   r_bias;
    logic [sndp_pkg::CNT_W-1:0]          r_active;

    // datapath
    logic                                w_adv;
    logic [sndp_pkg::CNT_W-1:0]          w_act_eff;
    logic signed [sndp_pkg::VAL_W-1:0]   w_x      [sndp_pkg::NUM_INPUTS];
    logic signed [sndp_pkg::PROD_W-1:0]  w_prod   [NUM_WEIGHTS];
    sndp_pkg::t_tag                      r_lane_tag;
    sndp_pkg::t_tag                      n_lane_tag;
    sndp_pkg::t_div_bus                  w_div    [sndp_pkg::QUO_W+1];

    // output register
    logic                                r_out_vld;
    logic signed [sndp_pkg::VAL_W-1:0]   r_out_act;
    logic signed [sndp_pkg::VAL_W-1:0]   n_out_act;
    logic                                r_out_short;

    // configuration writes, taken at any time the channel offers one
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_weights_low  <= '0;
            r_weights_high <= '0;
            r_bias         <= '0;
            r_active       <= sndp_pkg::ACTIVE_RESET;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                sndp_pkg::REG_WEIGHTS_LOW:  r_weights_low  <= i_cfg.data;
                sndp_pkg::REG_WEIGHTS_HIGH: r_weights_high <= i_cfg.data;
                sndp_pkg::REG_BIAS:         r_bias         <= i_cfg.data[sndp_pkg::VAL_W-1:0];
                sndp_pkg::REG_ACTIVE_COUNT: r_active       <= i_cfg.data[sndp_pkg::CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // whole pipeline advances unless a finished result is waiting
    assign w_adv        = !r_out_vld || o_result.ready;
    assign i_data.ready = w_adv;

    // active count clamped to the lanes built
    assign w_act_eff = (r_active > LANES) ? LANES : r_active;

    assign w_x[0] = i_data.input_value_0;
    assign w_x[1] = i_data.input_value_1;
    assign w_x[2] = i_data.input_value_2;
    assign w_x[3] = i_data.input_value_3;
    assign w_x[4] = i_data.input_value_4;
    assign w_x[5] = i_data.input_value_5;
    assign w_x[6] = i_data.input_value_6;
    assign w_x[7] = i_data.input_value_7;

    // multiply lanes; lane i only contributes when i is below the active count
    for (genvar i = 0; i < NUM_WEIGHTS; i++) begin : g_lane
        localparam int unsigned SH = sndp_pkg::VAL_W * (i % sndp_pkg::GROUP_SIZE);
        logic signed [sndp_pkg::VAL_W-1:0] w_wt;

        if (i < sndp_pkg::GROUP_SIZE) begin : g_low
            assign w_wt = r_weights_low[SH +: sndp_pkg::VAL_W];
        end else begin : g_high
            assign w_wt = r_weights_high[SH +: sndp_pkg::VAL_W];
        end

        sndp_lane u_lane (
            .i_clk  (i_clk),
            .i_en   (w_adv),
            .i_use  (sndp_pkg::CNT_W'(i) < w_act_eff),
            .i_x    (w_x[i]),
            .i_w    (w_wt),
            .o_prod (w_prod[i])
        );
    end

    // lane stage control: valid and short-vector flag
    always_comb begin
        n_lane_tag.vld     = i_data.valid;
        n_lane_tag.neg     = 1'b0;
        n_lane_tag.too_few = i_data.present_count < w_act_eff;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lane_tag.vld <= 1'b0;
        end else if (w_adv) begin
            r_lane_tag <= n_lane_tag;
        end
    end

    // adder tree and magnitude
    sndp_merge #(
        .NUM_WEIGHTS (NUM_WEIGHTS)
    ) u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_tag   (r_lane_tag),
        .i_prod  (w_prod),
        .i_bias  (r_bias),
        .o_div   (w_div[0])
    );

    // divider pipeline, most significant quotient bit first
    for (genvar k = 0; k < sndp_pkg::QUO_W; k++) begin : g_div
        sndp_div_stage u_div_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_adv),
            .i_div   (w_div[k]),
            .o_div   (w_div[k+1])
        );
    end

    // sign applied to the magnitude gives truncation toward zero
    always_comb begin
        if (w_div[sndp_pkg::QUO_W].tag.too_few) begin
            n_out_act = '0;
        end else if (w_div[sndp_pkg::QUO_W].tag.neg) begin
            n_out_act = -$signed({1'b0, w_div[sndp_pkg::QUO_W].quo});
        end else begin
            n_out_act = $signed({1'b0, w_div[sndp_pkg::QUO_W].quo});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_out_vld   <= w_div[sndp_pkg::QUO_W].tag.vld;
            r_out_act   <= n_out_act;
            r_out_short <= w_div[sndp_pkg::QUO_W].tag.too_few;
        end
    end

    assign o_result.valid          = r_out_vld;
    assign o_result.activation     = r_out_act;
    assign o_result.too_few_inputs = r_out_short;

    // a short vector always reports a zero activation
    a_short_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out_short) |-> (r_out_act == '0))
        else $error("short vector with non-zero activation");

    // softsign magnitude never reaches one
    a_no_min_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> (r_out_act != {1'b1, {(sndp_pkg::VAL_W-1){1'b0}}}))
        else $error("activation out of range");

    // an accepted transaction enters the lane stage
    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_data.valid && i_data.ready) |=> r_lane_tag.vld)
        else $error("accepted transaction lost at lane stage");

    // a stalled result is not overwritten
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !o_result.ready) |=> (r_out_vld && $stable(r_out_act)))
        else $error("waiting result changed");

endmodule
